// ===== hw/rtl/radix_string_converter_defines.svh =====
// Assertion macros shared by the radix string converter RTL.
// Included by radix_string_converter, the module that carries concurrent assertions; no other dependencies.
`ifndef RADIX_STRING_CONVERTER_DEFINES_SVH
`define RADIX_STRING_CONVERTER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define RSC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RSC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/rsc_pkg.sv =====
// Types, constants and helper functions for the radix string converter.
// Used by rsc_divider and radix_string_converter; depends on nothing.
package rsc_pkg;

   localparam int VALUE_BITS  = 16;
   localparam int MAX_DIGITS  = 16;
   localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W      = $clog2(MAX_DIGITS);
   localparam int DIGIT_W     = 4;
   localparam int BASE_W      = 5;
   localparam int CHAR_W      = 8;
   localparam int OUT_VALUE_W = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_DIGIT = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_BASE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_BASE   = 2'd1;

   localparam logic [BASE_W-1:0] SOURCE_BASE_RESET = 5'd10;
   localparam logic [BASE_W-1:0] DEST_BASE_RESET   = 5'd2;
   localparam logic [BASE_W-1:0] DEST_BASE_MIN     = 5'd2;
   localparam logic [BASE_W-1:0] DEST_BASE_MAX     = 5'd16;
   localparam logic [BASE_W-1:0] NOT_A_DIGIT       = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_SEND,
      ST_ERR
   } state_type;

   typedef struct packed {
      logic [CHAR_W-1:0] in_char;
      logic              end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0]      out_digit;
      logic [1:0]             status;
      logic [OUT_VALUE_W-1:0] value;
      logic [CHAR_W-1:0]      bad_char;
      logic                   last_digit;
   } rsp_payload_type;

   function automatic logic [BASE_W-1:0] decode_char(input logic [CHAR_W-1:0] c);
      logic [BASE_W-1:0] d;
      d = NOT_A_DIGIT;
      if (c >= "0" && c <= "9") begin
         d = BASE_W'(c - "0");
      end else if (c >= "A" && c <= "F") begin
         d = BASE_W'(c - "A" + 8'd10);
      end else if (c >= "a" && c <= "f") begin
         d = BASE_W'(c - "a" + 8'd10);
      end
      return d;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < 4'd10) begin
         c = "0" + CHAR_W'(d);
      end else begin
         c = "A" + CHAR_W'(d - 4'd10);
      end
      return c;
   endfunction

   function automatic logic [BASE_W-1:0] clamp_dest(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      r = b;
      if (b < DEST_BASE_MIN) begin
         r = DEST_BASE_MIN;
      end else if (b > DEST_BASE_MAX) begin
         r = DEST_BASE_MAX;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/rsc_divider.sv =====
// Restoring divider that retires one quotient bit per cycle.
// Depends on rsc_pkg; instantiated by radix_string_converter.
module rsc_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rsc_pkg::VALUE_BITS-1:0]   dividend,
   input  logic [rsc_pkg::BASE_W-1:0]       divisor,
   output logic                             done,
   output logic [rsc_pkg::VALUE_BITS-1:0]   quotient,
   output logic [rsc_pkg::DIGIT_W-1:0]      remainder
);
   import rsc_pkg::*;

   localparam int STEP_W = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [BASE_W-1:0]     rem_ff, rem_in;
   logic [BASE_W-1:0]     rem_shift;
   logic                  fits;

   always_comb begin
      rem_shift = {rem_ff[BASE_W-2:0], quo_ff[VALUE_BITS-1]};
      fits      = rem_shift >= divisor;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? rem_shift - divisor : rem_shift;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[DIGIT_W-1:0];

endmodule

// ===== hw/rtl/radix_string_converter.sv =====
// Channel     | Direction | Handshake            | Content
// req_        | in        | req_valid/req_ready  | one character and end-of-string flag
// rsp_        | out       | rsp_valid/rsp_ready  | one output digit or one error result
// csr_        | in        | csr_valid/csr_ready  | register index and base value
// A character that does not end the string is absorbed while the converter stays idle.
// The final character starts the digit pass: each output digit takes one division in the divider
// (a zero value skips it), then every result passes a digit memory read, then the transfer.
// Reset is synchronous and restores both bases; req_ready is low until the last result is taken.
// Top level of the radix string converter; depends on rsc_pkg, rsc_divider and the defines header.
`include "radix_string_converter_defines.svh"

module radix_string_converter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rsc_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output rsc_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rsc_pkg::BASE_W-1:0]         csr_wdata
);
   import rsc_pkg::*;

   localparam int PROD_W = VALUE_BITS + BASE_W + 1;

   state_type             state_ff, state_in;
   logic [BASE_W-1:0]     src_base_ff, src_base_in;
   logic [BASE_W-1:0]     dst_base_ff, dst_base_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [1:0]            err_ff, err_in;
   logic [CHAR_W-1:0]     bad_ff, bad_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [ADDR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [DIGIT_W-1:0]    rd_data_ff;
   logic [DIGIT_W-1:0]    digit_mem [MAX_DIGITS];

   logic                  req_xfer, rsp_xfer;
   logic [BASE_W-1:0]     digit;
   logic [PROD_W-1:0]     product;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_addr;
   logic [DIGIT_W-1:0]    mem_wdata;
   logic                  div_start, div_done;
   logic [VALUE_BITS-1:0] div_dividend, div_quotient;
   logic [DIGIT_W-1:0]    div_remainder;
   logic                  more_digits;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_SEND || state_ff == ST_ERR;
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   rsc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (clamp_dest(dst_base_ff)),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      src_base_in = src_base_ff;
      dst_base_in = dst_base_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SOURCE_BASE: src_base_in = csr_wdata;
            CSR_DEST_BASE:   dst_base_in = csr_wdata;
            default:         ;
         endcase
      end
   end

   always_comb begin
      digit        = decode_char(req_payload.in_char);
      product      = PROD_W'(acc_ff) * PROD_W'(src_base_ff) + PROD_W'(digit);
      more_digits  = 1'b0;
      acc_in       = acc_ff;
      err_in       = err_ff;
      bad_in       = bad_ff;
      cnt_in       = cnt_ff;
      rd_ptr_in    = rd_ptr_ff;
      mem_we       = 1'b0;
      mem_addr     = cnt_ff[ADDR_W-1:0];
      mem_wdata    = div_remainder;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (err_ff == STATUS_OK) begin
                  if (digit >= src_base_ff) begin
                     err_in = STATUS_BAD_DIGIT;
                     bad_in = req_payload.in_char;
                  end else if (product[PROD_W-1:VALUE_BITS] != '0) begin
                     err_in = STATUS_OVERFLOW;
                     acc_in = '0;
                  end else begin
                     acc_in = product[VALUE_BITS-1:0];
                  end
               end
               if (req_payload.end_of_string && err_in == STATUS_OK) begin
                  if (acc_in == '0) begin
                     mem_we    = 1'b1;
                     mem_addr  = '0;
                     mem_wdata = '0;
                     cnt_in    = CNT_W'(1);
                     rd_ptr_in = '0;
                  end else begin
                     div_start    = 1'b1;
                     div_dividend = acc_in;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mem_we      = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
               more_digits = div_quotient != '0 && cnt_in < CNT_W'(MAX_DIGITS);
               div_start   = more_digits;
               rd_ptr_in   = ADDR_W'(cnt_in - 1'b1);
            end
         end
         ST_READ: ;
         ST_SEND: begin
            if (rsp_xfer) begin
               if (rd_ptr_ff == '0) begin
                  acc_in = '0;
                  err_in = STATUS_OK;
                  bad_in = '0;
                  cnt_in = '0;
               end else begin
                  rd_ptr_in = rd_ptr_ff - 1'b1;
               end
            end
         end
         ST_ERR: begin
            if (rsp_xfer) begin
               acc_in = '0;
               err_in = STATUS_OK;
               bad_in = '0;
               cnt_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_payload.end_of_string) begin
               if (err_in != STATUS_OK) begin
                  state_in = ST_ERR;
               end else if (acc_in == '0) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done && !more_digits) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_xfer) begin
               state_in = (rd_ptr_ff == '0) ? ST_IDLE : ST_READ;
            end
         end
         ST_ERR: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_payload = '0;
      unique case (state_ff)
         ST_SEND: begin
            rsp_payload.out_digit  = digit_to_ascii(rd_data_ff);
            rsp_payload.status     = STATUS_OK;
            rsp_payload.value      = OUT_VALUE_W'(acc_ff);
            rsp_payload.last_digit = rd_ptr_ff == '0;
         end
         ST_ERR: begin
            rsp_payload.status     = err_ff;
            rsp_payload.bad_char   = bad_ff;
            rsp_payload.last_digit = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[mem_addr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= digit_mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         src_base_ff <= SOURCE_BASE_RESET;
         dst_base_ff <= DEST_BASE_RESET;
         acc_ff      <= '0;
         err_ff      <= STATUS_OK;
         bad_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         src_base_ff <= src_base_in;
         dst_base_ff <= dst_base_in;
         acc_ff      <= acc_in;
         err_ff      <= err_in;
         bad_ff      <= bad_in;
         cnt_ff      <= cnt_in;
      end
      rd_ptr_ff <= rd_ptr_in;
   end

   `RSC_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == ST_IDLE, "reset did not return to idle")
   `RSC_ASSERT(a_no_overlap, req_ready |-> !rsp_valid, "input taken while a result is pending")
   `RSC_ASSERT(a_done_in_div, div_done |-> state_ff == ST_DIV, "divider finished outside digit pass")
   `RSC_ASSERT(a_error_last, (rsp_valid && rsp_payload.status != STATUS_OK) |-> rsp_payload.last_digit, "error result not marked last")
   `RSC_ASSERT(a_count_range, cnt_ff <= CNT_W'(MAX_DIGITS), "digit count beyond memory depth")

endmodule
